### hw/rtl/ssh_pkg.sv
// shared constants, types and job format of the stop sequence matcher
`timescale 1ns / 1ps

package ssh_pkg;

  // design sizes
  localparam int MAX_LEN    = 8;
  localparam int NUM_PAT    = 4;
  localparam int HOLD_DEPTH = MAX_LEN - 1;
  localparam int HC_W       = $clog2(MAX_LEN);
  localparam int CNT_W      = $clog2(MAX_LEN + 1);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // fixed field widths
  localparam int PAT_W   = 64;
  localparam int LEN_W   = 4;
  localparam int CFG_W   = 64;
  localparam int CIDX_W  = 4;
  localparam int BYTE_W  = 8;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_PATTERN_0 = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_PATTERN_3 = CIDX_W'(3);
  localparam logic [CIDX_W-1:0] REG_LENGTH_0  = CIDX_W'(4);
  localparam logic [CIDX_W-1:0] REG_LENGTH_3  = CIDX_W'(7);

  // input item kinds
  localparam logic KIND_TEXT  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef logic [MAX_LEN-1:0][BYTE_W-1:0] ssh_win_t;

  // one unit of work for the output side: window bytes newest first,
  // emit count bytes from index top downward, then an optional stop marker
  typedef struct packed {
    ssh_win_t         bytes;
    logic [HC_W-1:0]  top;
    logic [CNT_W-1:0] count;
    logic             stop;
  } ssh_job_t;

endpackage

### hw/rtl/ssh_if.sv
// handshake channels for input items and result items
`timescale 1ns / 1ps

interface ssh_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface ssh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_stop;
  logic       last;

  modport source (output valid, output out_byte, output is_stop, output last, input ready);
  modport sink   (input valid, input out_byte, input is_stop, input last, output ready);
endinterface

### hw/rtl/ssh_front.sv
// front end: pattern registers, held bytes, match and holdback decision per item
`timescale 1ns / 1ps

module ssh_front
  import ssh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ssh_in_if.sink            in_ch,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              q_full,
  output logic              push,
  output ssh_job_t          job
);

  logic [NUM_PAT-1:0][PAT_W-1:0] pat_r;
  logic [NUM_PAT-1:0][LEN_W-1:0] len_r;
  logic [HOLD_DEPTH-1:0][BYTE_W-1:0] held_r, held_nxt;
  logic [HC_W-1:0] hc_r, hc_nxt;
  logic stopped_r, stopped_nxt;

  ssh_win_t ra;
  logic [CNT_W-1:0] w;
  logic [NUM_PAT-1:0][CNT_W-1:0] lc;
  logic [NUM_PAT-1:0][MAX_LEN-1:0] eq;
  logic [NUM_PAT-1:0] hit;
  logic matched;
  logic [CNT_W-1:0] mlen;
  logic [MAX_LEN-1:1] cand;
  logic [CNT_W-1:0] k;
  logic job_valid;
  logic accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // window newest first: new byte, then held bytes
  always_comb begin
    ra[0] = in_ch.data_byte;
    for (int i = 1; i < MAX_LEN; i++) begin
      ra[i] = held_r[i-1];
    end
    w = CNT_W'(hc_r) + CNT_W'(1);
  end

  // clamped lengths and suffix-versus-prefix compares for every length
  always_comb begin
    for (int p = 0; p < NUM_PAT; p++) begin
      lc[p] = (len_r[p] > LEN_W'(MAX_LEN)) ? CNT_W'(MAX_LEN) : CNT_W'(len_r[p]);
      for (int c = 1; c <= MAX_LEN; c++) begin
        eq[p][c-1] = 1'b1;
        for (int j = 0; j < c; j++) begin
          if (ra[c-1-j] != pat_r[p][BYTE_W*j +: BYTE_W]) begin
            eq[p][c-1] = 1'b0;
          end
        end
      end
    end
  end

  // full match, lowest numbered pattern wins
  always_comb begin
    logic [CNT_W-1:0] lm1;
    matched = 1'b0;
    mlen    = '0;
    for (int p = 0; p < NUM_PAT; p++) begin
      lm1    = lc[p] - CNT_W'(1);
      hit[p] = (lc[p] != '0) && (lc[p] <= w) && eq[p][lm1[HC_W-1:0]];
    end
    for (int p = NUM_PAT - 1; p >= 0; p--) begin
      if (hit[p]) begin
        matched = 1'b1;
        mlen    = lc[p];
      end
    end
  end

  // longest window suffix that is a proper prefix of some pattern
  always_comb begin
    cand = '0;
    k    = '0;
    for (int c = 1; c < MAX_LEN; c++) begin
      for (int p = 0; p < NUM_PAT; p++) begin
        if ((lc[p] > CNT_W'(c)) && (w >= CNT_W'(c)) && eq[p][c-1]) begin
          cand[c] = 1'b1;
        end
      end
    end
    for (int c = 1; c < MAX_LEN; c++) begin
      if (cand[c]) begin
        k = CNT_W'(c);
      end
    end
  end

  // job and next state
  always_comb begin
    held_nxt    = held_r;
    hc_nxt      = hc_r;
    stopped_nxt = stopped_r;
    job.bytes   = ra;
    job.top     = hc_r;
    job.count   = '0;
    job.stop    = 1'b0;
    job_valid   = 1'b0;
    if (in_ch.kind == KIND_FLUSH) begin
      job.count   = CNT_W'(hc_r);
      job_valid   = (hc_r != '0);
      hc_nxt      = '0;
      stopped_nxt = 1'b0;
    end else if (!stopped_r) begin
      if (matched) begin
        job.count   = w - mlen;
        job.stop    = 1'b1;
        job_valid   = 1'b1;
        hc_nxt      = '0;
        stopped_nxt = 1'b1;
      end else begin
        job.count = w - k;
        job_valid = (w != k);
        for (int i = 0; i < HOLD_DEPTH; i++) begin
          held_nxt[i] = ra[i];
        end
        hc_nxt = k[HC_W-1:0];
      end
    end
  end

  assign push = accept && job_valid;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r      <= '0;
      stopped_r <= 1'b0;
    end else if (accept) begin
      hc_r      <= hc_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // held bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
      len_r <= '0;
    end else if (cfg_we) begin
      for (int p = 0; p < NUM_PAT; p++) begin
        if (cfg_index == REG_PATTERN_0 + CIDX_W'(p)) begin
          pat_r[p] <= cfg_data;
        end
        if (cfg_index == REG_LENGTH_0 + CIDX_W'(p)) begin
          len_r[p] <= cfg_data[LEN_W-1:0];
        end
      end
    end
  end

  // a flush leaves nothing held and clears the stop
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.kind == KIND_FLUSH |=> hc_r == '0 && !stopped_r)
    else $error("flush did not clear state");

  // text after a stop produces no work
  a_stopped_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.kind == KIND_TEXT && stopped_r |-> !push)
    else $error("work pushed while stopped");

endmodule

### hw/rtl/ssh_queue.sv
// short job queue between front and back end
`timescale 1ns / 1ps

module ssh_queue
  import ssh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ssh_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     nonempty,
  output ssh_job_t head
);

  ssh_job_t mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QPTR_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !nonempty))
    else $error("pop from empty queue");

endmodule

### hw/rtl/ssh_back.sv
// back end: plays out each job as released bytes and an optional stop marker
`timescale 1ns / 1ps

module ssh_back
  import ssh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_nonempty,
  input  ssh_job_t q_head,
  output logic     pop,
  ssh_out_if.source out_ch
);

  ssh_win_t         bytes_r;
  logic [HC_W-1:0]  ptr_r;
  logic [CNT_W-1:0] rem_r;
  logic             stop_r;
  logic             busy_r;
  logic             done;

  // current result item
  always_comb begin
    out_ch.valid = busy_r;
    if (rem_r != '0) begin
      out_ch.out_byte = bytes_r[ptr_r];
      out_ch.is_stop  = 1'b0;
      out_ch.last     = (rem_r == CNT_W'(1)) && !stop_r;
    end else begin
      out_ch.out_byte = '0;
      out_ch.is_stop  = 1'b1;
      out_ch.last     = 1'b1;
    end
  end

  assign done = out_ch.valid && out_ch.ready && out_ch.last;
  assign pop  = q_nonempty && (!busy_r || done);

  // job sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= '0;
      stop_r <= 1'b0;
    end else if (pop) begin
      busy_r <= 1'b1;
      rem_r  <= q_head.count;
      stop_r <= q_head.stop;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      rem_r <= rem_r - CNT_W'(1);
    end
  end

  // payload of the current job
  always_ff @(posedge clk) begin
    if (pop) begin
      bytes_r <= q_head.bytes;
      ptr_r   <= q_head.top;
    end else if (out_ch.valid && out_ch.ready) begin
      ptr_r <= ptr_r - HC_W'(1);
    end
  end

  a_stop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_stop |-> out_ch.last && out_ch.out_byte == '0)
    else $error("stop marker not final or not zero");

endmodule

### hw/rtl/stop_sequence_holdback_matcher.sv
// Path: an accepted item's job enters the job queue and is popped into the output
// registers before its first result is valid; an item that only adds to held bytes gives
// none. Throughput: one input item per cycle while each gives at most one result and
// out_ch.ready is high; the output emits one result per cycle while ready, an item with
// n results holds it until all are taken, and the two-entry job queue lets the input
// run ahead. Reset: synchronous active-low rst_n clears pattern registers, held count,
// stop flag, queue and output state; no clearing pass.
`timescale 1ns / 1ps

module stop_sequence_holdback_matcher
  import ssh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ssh_in_if.sink            in_ch,
  ssh_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic     q_full;
  logic     push;
  ssh_job_t job;
  logic     pop;
  logic     q_nonempty;
  ssh_job_t q_head;

  // classify items and track held bytes
  ssh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .job       (job)
  );

  // decoupling queue
  ssh_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (job),
    .full     (q_full),
    .pop      (pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  // play out results
  ssh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
